// ----- sv/lfcp_pkg.sv -----
`timescale 1ns / 1ps

package lfcp_pkg;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_TAKE  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [7:0] ID_VOLUME    = 8'd1;
   localparam logic [7:0] ID_CHANNEL   = 8'd2;
   localparam logic [7:0] ID_SEEK_UP   = 8'd3;
   localparam logic [7:0] ID_SEEK_DOWN = 8'd4;

   localparam logic [7:0] MIN_FRAME_LENGTH = 8'd2;

   localparam int FLAG_VOLUME    = 0;
   localparam int FLAG_CHANNEL   = 1;
   localparam int FLAG_SEEK_UP   = 2;
   localparam int FLAG_SEEK_DOWN = 3;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        frame_ok;
      logic        malformed;
      logic        closed;
      logic [3:0]  pend_mask;
      logic [7:0]  volume_value;
      logic [15:0] channel_value;
      logic        taken;
   } rsp_type;

endpackage

// ----- sv/lfcp_if.sv -----
`timescale 1ns / 1ps

interface lfcp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface lfcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic        malformed;
   logic        closed;
   logic        pend_volume;
   logic        pend_channel;
   logic        pend_seek_up;
   logic        pend_seek_down;
   logic [7:0]  volume_value;
   logic [15:0] channel_value;
   logic        taken;

   modport source (
      output valid, output frame_ok, output malformed, output closed,
      output pend_volume, output pend_channel, output pend_seek_up,
      output pend_seek_down, output volume_value, output channel_value,
      output taken, input ready
   );
   modport sink (
      input valid, input frame_ok, input malformed, input closed,
      input pend_volume, input pend_channel, input pend_seek_up,
      input pend_seek_down, input volume_value, input channel_value,
      input taken, output ready
   );
endinterface

// ----- sv/lfcp_core.sv -----
`timescale 1ns / 1ps

module lfcp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  lfcp_pkg::req_type item,
   output lfcp_pkg::rsp_type result
);

   logic [7:0]  frame_left_ff, frame_left_in;
   logic [1:0]  event_phase_ff, event_phase_in;
   logic [1:0]  event_kind_ff, event_kind_in;
   logic        frame_bad_ff, frame_bad_in;
   logic [3:0]  frame_mask_ff, frame_mask_in;
   logic [7:0]  frame_volume_ff, frame_volume_in;
   logic [15:0] frame_channel_ff, frame_channel_in;
   logic [3:0]  pending_mask_ff, pending_mask_in;
   logic [7:0]  held_volume_ff, held_volume_in;
   logic [15:0] held_channel_ff, held_channel_in;
   logic        rejected_ff, rejected_in;

   logic       ok;
   logic       bad;
   logic       taken;
   logic [3:0] shown;

   always_comb begin
      frame_left_in    = frame_left_ff;
      event_phase_in   = event_phase_ff;
      event_kind_in    = event_kind_ff;
      frame_bad_in     = frame_bad_ff;
      frame_mask_in    = frame_mask_ff;
      frame_volume_in  = frame_volume_ff;
      frame_channel_in = frame_channel_ff;
      pending_mask_in  = pending_mask_ff;
      held_volume_in   = held_volume_ff;
      held_channel_in  = held_channel_ff;
      rejected_in      = rejected_ff;
      ok    = 1'b0;
      bad   = 1'b0;
      taken = 1'b0;
      shown = pending_mask_ff;

      unique case (item.command)
         lfcp_pkg::CMD_BYTE: begin
            if (!rejected_ff) begin
               if (frame_left_ff == 8'd0) begin
                  event_phase_in   = 2'd0;
                  event_kind_in    = 2'd0;
                  frame_bad_in     = 1'b0;
                  frame_mask_in    = 4'd0;
                  frame_volume_in  = 8'd0;
                  frame_channel_in = 16'd0;
                  if (item.data_byte < lfcp_pkg::MIN_FRAME_LENGTH) begin
                     bad         = 1'b1;
                     rejected_in = 1'b1;
                  end else begin
                     frame_left_in = item.data_byte - 8'd1;
                  end
               end else begin
                  if (!frame_bad_ff) begin
                     if (event_phase_ff == 2'd0) begin
                        unique case (item.data_byte)
                           lfcp_pkg::ID_VOLUME: begin
                              event_kind_in  = lfcp_pkg::ID_VOLUME[1:0];
                              event_phase_in = 2'd1;
                           end
                           lfcp_pkg::ID_CHANNEL: begin
                              event_kind_in  = lfcp_pkg::ID_CHANNEL[1:0];
                              event_phase_in = 2'd1;
                           end
                           lfcp_pkg::ID_SEEK_UP: begin
                              frame_mask_in[lfcp_pkg::FLAG_SEEK_UP] = 1'b1;
                           end
                           lfcp_pkg::ID_SEEK_DOWN: begin
                              frame_mask_in[lfcp_pkg::FLAG_SEEK_DOWN] = 1'b1;
                           end
                           default: begin
                              frame_bad_in = 1'b1;
                           end
                        endcase
                     end else if (event_kind_ff == lfcp_pkg::ID_VOLUME[1:0]) begin
                        frame_volume_in = item.data_byte;
                        frame_mask_in[lfcp_pkg::FLAG_VOLUME] = 1'b1;
                        event_phase_in = 2'd0;
                     end else if (event_phase_ff == 2'd1) begin
                        frame_channel_in = {item.data_byte, 8'h00};
                        event_phase_in   = 2'd2;
                     end else begin
                        frame_channel_in = {frame_channel_ff[15:8], item.data_byte};
                        frame_mask_in[lfcp_pkg::FLAG_CHANNEL] = 1'b1;
                        event_phase_in = 2'd0;
                     end
                  end
                  frame_left_in = frame_left_ff - 8'd1;
                  if (frame_left_ff == 8'd1) begin
                     if (frame_bad_in || (event_phase_in != 2'd0)) begin
                        bad         = 1'b1;
                        rejected_in = 1'b1;
                     end else begin
                        ok              = 1'b1;
                        pending_mask_in = pending_mask_ff | frame_mask_in;
                        if (frame_mask_in[lfcp_pkg::FLAG_VOLUME]) begin
                           held_volume_in = frame_volume_in;
                        end
                        if (frame_mask_in[lfcp_pkg::FLAG_CHANNEL]) begin
                           held_channel_in = frame_channel_in;
                        end
                     end
                     frame_left_in    = 8'd0;
                     event_phase_in   = 2'd0;
                     event_kind_in    = 2'd0;
                     frame_bad_in     = 1'b0;
                     frame_mask_in    = 4'd0;
                     frame_volume_in  = 8'd0;
                     frame_channel_in = 16'd0;
                  end
               end
            end
            shown = pending_mask_in;
         end
         lfcp_pkg::CMD_TAKE: begin
            pending_mask_in = 4'd0;
            taken           = 1'b1;
         end
         lfcp_pkg::CMD_RESET: begin
            frame_left_in    = 8'd0;
            event_phase_in   = 2'd0;
            event_kind_in    = 2'd0;
            frame_bad_in     = 1'b0;
            frame_mask_in    = 4'd0;
            frame_volume_in  = 8'd0;
            frame_channel_in = 16'd0;
            rejected_in      = 1'b0;
         end
         lfcp_pkg::CMD_NONE: begin
            shown = pending_mask_ff;
         end
         default: begin
            shown = pending_mask_ff;
         end
      endcase
   end

   always_comb begin
      result.frame_ok      = ok;
      result.malformed     = bad;
      result.closed        = rejected_in;
      result.pend_mask     = shown;
      result.volume_value  = held_volume_in;
      result.channel_value = held_channel_in;
      result.taken         = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_left_ff    <= 8'd0;
         event_phase_ff   <= 2'd0;
         event_kind_ff    <= 2'd0;
         frame_bad_ff     <= 1'b0;
         frame_mask_ff    <= 4'd0;
         frame_volume_ff  <= 8'd0;
         frame_channel_ff <= 16'd0;
         pending_mask_ff  <= 4'd0;
         held_volume_ff   <= 8'd0;
         held_channel_ff  <= 16'd0;
         rejected_ff      <= 1'b0;
      end else if (step) begin
         frame_left_ff    <= frame_left_in;
         event_phase_ff   <= event_phase_in;
         event_kind_ff    <= event_kind_in;
         frame_bad_ff     <= frame_bad_in;
         frame_mask_ff    <= frame_mask_in;
         frame_volume_ff  <= frame_volume_in;
         frame_channel_ff <= frame_channel_in;
         pending_mask_ff  <= pending_mask_in;
         held_volume_ff   <= held_volume_in;
         held_channel_ff  <= held_channel_in;
         rejected_ff      <= rejected_in;
      end
   end

endmodule

// ----- sv/length_framed_command_parser.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload
// req_bus   in         command, data_byte
// rsp_bus   out        frame_ok, malformed, closed, pend_*, volume_value,
//                      channel_value, taken
//
// One item per cycle is sustained while rsp_bus.ready stays high; every item
// yields one result, held first in the input register and then in the result
// register. The parser state updates once per item. Reset is synchronous and
// clears the valid flags and the parser state; a stalled result holds the
// result register and, one item later, the input register.

module length_framed_command_parser (
   input logic        clock,
   input logic        reset,
   lfcp_req_if.sink   req_bus,
   lfcp_rsp_if.source rsp_bus
);

   logic              in_valid_ff;
   lfcp_pkg::req_type in_item_ff;
   logic              rsp_valid_ff;
   lfcp_pkg::rsp_type rsp_item_ff;
   lfcp_pkg::rsp_type result;
   logic              step;
   logic              req_take;

   assign step          = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take      = req_bus.valid && req_bus.ready;

   lfcp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command   <= lfcp_pkg::cmd_type'(req_bus.command);
         in_item_ff.data_byte <= req_bus.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.frame_ok       = rsp_item_ff.frame_ok;
   assign rsp_bus.malformed      = rsp_item_ff.malformed;
   assign rsp_bus.closed         = rsp_item_ff.closed;
   assign rsp_bus.pend_volume    = rsp_item_ff.pend_mask[lfcp_pkg::FLAG_VOLUME];
   assign rsp_bus.pend_channel   = rsp_item_ff.pend_mask[lfcp_pkg::FLAG_CHANNEL];
   assign rsp_bus.pend_seek_up   = rsp_item_ff.pend_mask[lfcp_pkg::FLAG_SEEK_UP];
   assign rsp_bus.pend_seek_down = rsp_item_ff.pend_mask[lfcp_pkg::FLAG_SEEK_DOWN];
   assign rsp_bus.volume_value   = rsp_item_ff.volume_value;
   assign rsp_bus.channel_value  = rsp_item_ff.channel_value;
   assign rsp_bus.taken          = rsp_item_ff.taken;

endmodule

// ----- sv/lfcp_checker.sv -----
`timescale 1ns / 1ps

module lfcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        frame_ok,
   input logic        malformed,
   input logic        closed,
   input logic        taken,
   input logic [7:0]  volume_value,
   input logic [15:0] channel_value
);

   // A result is never presented in the cycle right after reset.
   a_idle_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its values until it is transferred.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(frame_ok) && $stable(malformed) && $stable(closed)
          && $stable(taken) && $stable(volume_value) && $stable(channel_value)))
      else $error("stalled result changed");

   // A byte cannot both commit and reject a frame, and a take carries no frame end.
   a_outcome_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(frame_ok && malformed) && !(taken && (frame_ok || malformed)))
      else $error("conflicting frame outcome");

   // A rejected frame always leaves the connection closed.
   a_malformed_closes : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && malformed) |-> closed)
      else $error("malformed frame without close");

   // A committed frame proves the connection was open.
   a_ok_open : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && frame_ok) |-> !closed)
      else $error("frame committed on a closed connection");

endmodule

bind length_framed_command_parser lfcp_checker u_lfcp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .frame_ok      (rsp_bus.frame_ok),
   .malformed     (rsp_bus.malformed),
   .closed        (rsp_bus.closed),
   .taken         (rsp_bus.taken),
   .volume_value  (rsp_bus.volume_value),
   .channel_value (rsp_bus.channel_value)
);

// ----- bench/length_framed_command_parser_checker.sv -----
`timescale 1ns / 1ps

module length_framed_command_parser_checker (
   input logic  clock,
   input logic  reset,
   lfcp_req_if  req_bus,
   lfcp_rsp_if  rsp_bus,
   output int   mismatch_count,
   output int   replies_due
);

   logic [7:0]  bytes_to_go;
   logic [1:0]  value_count;
   logic [7:0]  open_kind;
   logic        frame_broken;
   logic [3:0]  frame_flags;
   logic [7:0]  frame_vol;
   logic [15:0] frame_chan;
   logic [3:0]  pend_flags;
   logic [7:0]  cur_vol;
   logic [15:0] cur_chan;
   logic        conn_closed;

   lfcp_pkg::rsp_type expected_replies[$];

   function void clear_frame();
      bytes_to_go = '0;
      value_count = '0;
      open_kind = '0;
      frame_broken = 1'b0;
      frame_flags = '0;
      frame_vol = '0;
      frame_chan = '0;
   endfunction

   function lfcp_pkg::rsp_type parse_step(lfcp_pkg::cmd_type cmd, logic [7:0] b);
      lfcp_pkg::rsp_type r;
      r = '0;
      case (cmd)
         lfcp_pkg::CMD_BYTE: begin
            if (conn_closed) begin
               // The byte is dropped.
            end else if (bytes_to_go == 0) begin
               clear_frame();
               if (b < lfcp_pkg::MIN_FRAME_LENGTH) begin
                  r.malformed = 1'b1;
                  conn_closed = 1'b1;
               end else begin
                  bytes_to_go = b - 8'd1;
               end
            end else begin
               if (!frame_broken) begin
                  if (value_count == 0) begin
                     case (b)
                        lfcp_pkg::ID_VOLUME: begin
                           open_kind = lfcp_pkg::ID_VOLUME;
                           value_count = 2'd1;
                        end
                        lfcp_pkg::ID_CHANNEL: begin
                           open_kind = lfcp_pkg::ID_CHANNEL;
                           value_count = 2'd1;
                        end
                        lfcp_pkg::ID_SEEK_UP:
                           frame_flags[lfcp_pkg::FLAG_SEEK_UP] = 1'b1;
                        lfcp_pkg::ID_SEEK_DOWN:
                           frame_flags[lfcp_pkg::FLAG_SEEK_DOWN] = 1'b1;
                        default: frame_broken = 1'b1;
                     endcase
                  end else if (open_kind == lfcp_pkg::ID_VOLUME) begin
                     frame_vol = b;
                     frame_flags[lfcp_pkg::FLAG_VOLUME] = 1'b1;
                     value_count = 2'd0;
                  end else if (value_count == 1) begin
                     frame_chan = {b, 8'h00};
                     value_count = 2'd2;
                  end else begin
                     frame_chan[7:0] = b;
                     frame_flags[lfcp_pkg::FLAG_CHANNEL] = 1'b1;
                     value_count = 2'd0;
                  end
               end
               bytes_to_go = bytes_to_go - 8'd1;
               if (bytes_to_go == 0) begin
                  if (frame_broken || value_count != 0) begin
                     r.malformed = 1'b1;
                     conn_closed = 1'b1;
                  end else begin
                     r.frame_ok = 1'b1;
                     pend_flags = pend_flags | frame_flags;
                     if (frame_flags[lfcp_pkg::FLAG_VOLUME]) begin
                        cur_vol = frame_vol;
                     end
                     if (frame_flags[lfcp_pkg::FLAG_CHANNEL]) begin
                        cur_chan = frame_chan;
                     end
                  end
                  clear_frame();
               end
            end
            r.pend_mask = pend_flags;
         end
         lfcp_pkg::CMD_TAKE: begin
            r.pend_mask = pend_flags;
            pend_flags = '0;
            r.taken = 1'b1;
         end
         lfcp_pkg::CMD_RESET: begin
            clear_frame();
            conn_closed = 1'b0;
            r.pend_mask = pend_flags;
         end
         default: begin
            r.pend_mask = pend_flags;
         end
      endcase
      r.closed = conn_closed;
      r.volume_value = cur_vol;
      r.channel_value = cur_chan;
      return r;
   endfunction

   function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("lfcp mismatch at %0t: %s expected %0h, got %0h", $realtime, field,
                     want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      lfcp_pkg::rsp_type want;
      if (reset) begin
         clear_frame();
         pend_flags = '0;
         cur_vol = '0;
         cur_chan = '0;
         conn_closed = 1'b0;
         expected_replies.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("lfcp mismatch at %0t: result transfer with none expected",
                           $realtime);
               end
            end else begin
               want = expected_replies.pop_front();
               check_field("frame_ok", want.frame_ok, rsp_bus.frame_ok);
               check_field("malformed", want.malformed, rsp_bus.malformed);
               check_field("closed", want.closed, rsp_bus.closed);
               check_field("pend_volume", want.pend_mask[lfcp_pkg::FLAG_VOLUME],
                           rsp_bus.pend_volume);
               check_field("pend_channel", want.pend_mask[lfcp_pkg::FLAG_CHANNEL],
                           rsp_bus.pend_channel);
               check_field("pend_seek_up", want.pend_mask[lfcp_pkg::FLAG_SEEK_UP],
                           rsp_bus.pend_seek_up);
               check_field("pend_seek_down", want.pend_mask[lfcp_pkg::FLAG_SEEK_DOWN],
                           rsp_bus.pend_seek_down);
               check_field("volume_value", want.volume_value, rsp_bus.volume_value);
               check_field("channel_value", want.channel_value, rsp_bus.channel_value);
               check_field("taken", want.taken, rsp_bus.taken);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_replies.push_back(parse_step(lfcp_pkg::cmd_type'(req_bus.command),
                                                  req_bus.data_byte));
         end
      end
      replies_due <= expected_replies.size();
   end

endmodule

// ----- bench/length_framed_command_parser_tb.sv -----
`timescale 1ns / 1ps

module length_framed_command_parser_tb;

   localparam int FLAW_NONE      = 0;
   localparam int FLAW_BAD_ID    = 1;
   localparam int FLAW_TRUNCATED = 2;
   localparam int FLAW_SHORT     = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   replies_due;
   int   items_sent;
   int   burst_left;

   lfcp_req_if req_bus ();
   lfcp_rsp_if rsp_bus ();

   length_framed_command_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   length_framed_command_parser_checker reply_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .replies_due    (replies_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic push_item(lfcp_pkg::cmd_type cmd, logic [7:0] b);
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (replies_due != 0);
   endtask

   task automatic play_frame(int body_len, int flaw);
      logic [7:0] body[$];
      int         starts[$];
      int         kind;
      int         room;
      int         spot;
      room = 0;
      while (body.size() < body_len) begin
         room = body_len - body.size();
         starts.push_back(body.size());
         kind = $urandom_range(lfcp_pkg::ID_VOLUME, lfcp_pkg::ID_SEEK_DOWN);
         if (kind == lfcp_pkg::ID_CHANNEL && room < 3) begin
            kind = lfcp_pkg::ID_VOLUME;
         end
         if (kind == lfcp_pkg::ID_VOLUME && room < 2) begin
            kind = $urandom_range(lfcp_pkg::ID_SEEK_UP, lfcp_pkg::ID_SEEK_DOWN);
         end
         body.push_back(8'(kind));
         if (kind == lfcp_pkg::ID_VOLUME) begin
            body.push_back(8'($urandom_range(0, 255)));
         end else if (kind == lfcp_pkg::ID_CHANNEL) begin
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back(8'($urandom_range(0, 255)));
         end
      end
      if (flaw == FLAW_BAD_ID) begin
         spot = starts[$urandom_range(0, starts.size() - 1)];
         body.insert(spot, $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255)));
      end else if (flaw == FLAW_TRUNCATED) begin
         if ($urandom_range(0, 1)) begin
            body.push_back(lfcp_pkg::ID_VOLUME);
         end else begin
            body.push_back(lfcp_pkg::ID_CHANNEL);
            if ($urandom_range(0, 1)) begin
               body.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      if (flaw == FLAW_SHORT) begin
         push_item(lfcp_pkg::CMD_BYTE, 8'($urandom_range(0, 1)));
      end else begin
         push_item(lfcp_pkg::CMD_BYTE, 8'(body.size() + 1));
      end
      foreach (body[i]) begin
         if ($urandom_range(0, 99) < 6) begin
            push_item(lfcp_pkg::CMD_TAKE, 8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 99) < 2) begin
            push_item(lfcp_pkg::CMD_NONE, 8'($urandom_range(0, 255)));
         end
         push_item(lfcp_pkg::CMD_BYTE, body[i]);
      end
      if (flaw != FLAW_NONE && $urandom_range(0, 9) != 0) begin
         push_item(lfcp_pkg::CMD_RESET, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int mode;
      int beat;
      beat = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(50, 200)) begin
            @(posedge clock);
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ((beat % 9) < 2);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
            beat++;
         end
      end
   end

   initial begin
      #5000000;
      $display("[length_framed_command_parser] ERROR");
      $finish;
   end

   initial begin
      int  pick;
      int  body_len;
      int  flaw;
      bit  drained;
      drained = 1'b0;
      items_sent = 0;
      burst_left = 4;
      req_bus.valid <= 1'b0;
      req_bus.command <= lfcp_pkg::CMD_NONE;
      req_bus.data_byte <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Short length bytes, a byte while closed and reconnects.
      push_item(lfcp_pkg::CMD_BYTE, 8'h00);
      push_item(lfcp_pkg::CMD_BYTE, 8'hFF);
      push_item(lfcp_pkg::CMD_RESET, 8'h00);
      push_item(lfcp_pkg::CMD_BYTE, 8'h01);
      push_item(lfcp_pkg::CMD_RESET, 8'hFF);
      // One frame holding every event, then a take, an empty take and a no-op.
      push_item(lfcp_pkg::CMD_BYTE, 8'd8);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_VOLUME);
      push_item(lfcp_pkg::CMD_BYTE, 8'hFF);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_CHANNEL);
      push_item(lfcp_pkg::CMD_BYTE, 8'hAB);
      push_item(lfcp_pkg::CMD_BYTE, 8'hCD);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_SEEK_UP);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_SEEK_DOWN);
      push_item(lfcp_pkg::CMD_TAKE, 8'h00);
      push_item(lfcp_pkg::CMD_TAKE, 8'hFF);
      push_item(lfcp_pkg::CMD_NONE, 8'hAA);
      // A take in the middle of a frame must not disturb it.
      push_item(lfcp_pkg::CMD_BYTE, 8'd4);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_CHANNEL);
      push_item(lfcp_pkg::CMD_TAKE, 8'h55);
      push_item(lfcp_pkg::CMD_BYTE, 8'h00);
      push_item(lfcp_pkg::CMD_BYTE, 8'h00);
      // An unknown event id, then a truncated channel event.
      push_item(lfcp_pkg::CMD_BYTE, 8'd3);
      push_item(lfcp_pkg::CMD_BYTE, 8'h00);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_VOLUME);
      push_item(lfcp_pkg::CMD_RESET, 8'h00);
      push_item(lfcp_pkg::CMD_BYTE, 8'd3);
      push_item(lfcp_pkg::CMD_BYTE, lfcp_pkg::ID_CHANNEL);
      push_item(lfcp_pkg::CMD_BYTE, 8'hFF);
      push_item(lfcp_pkg::CMD_RESET, 8'h00);

      while (items_sent < 945) begin
         if (!drained && items_sent > 500) begin
            wait_idle();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            flaw = ($urandom_range(0, 99) < 80) ? FLAW_NONE : $urandom_range(1, 3);
            if ($urandom_range(0, 99) < 3) begin
               body_len = $urandom_range(200, (flaw == FLAW_NONE) ? 254 : 250);
            end else begin
               body_len = $urandom_range(1, 10);
            end
            play_frame(body_len, flaw);
         end else if (pick < 83) begin
            push_item(lfcp_pkg::CMD_TAKE, 8'($urandom_range(0, 255)));
         end else if (pick < 86) begin
            push_item(lfcp_pkg::CMD_RESET, 8'($urandom_range(0, 255)));
         end else if (pick < 88) begin
            push_item(lfcp_pkg::CMD_NONE, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 5)) begin
               push_item(lfcp_pkg::cmd_type'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 7) begin
               push_item(lfcp_pkg::CMD_RESET, 8'($urandom_range(0, 255)));
            end
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[length_framed_command_parser] OK");
      end else begin
         $display("[length_framed_command_parser] ERROR");
      end
      $finish;
   end

endmodule
